@@ sv/maze_flood_fill_defines.svh @@
// assertion macros for the maze flood fill block
// expects clk and rst_n in the module that uses them
`ifndef MAZE_FLOOD_FILL_DEFINES_SVH
`define MAZE_FLOOD_FILL_DEFINES_SVH

// condition must hold at every clock out of reset
`define MFF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger implies condition in the same cycle
`define MFF_ASSERT_IMP(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

`endif

@@ sv/mff_pkg.sv @@
// shared types and constants for the maze flood fill block
// used by the controller, the datapath and the top level
package mff_pkg;

  localparam int GRID_SIDE_DEF = 8;

  localparam logic [7:0] DIST_NONE = 8'd255;
  localparam logic [7:0] DIST_LAST = 8'd254;

  localparam logic [1:0] OP_WALL  = 2'd0;
  localparam logic [1:0] OP_FLOOD = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] SIDE_N = 2'd0;
  localparam logic [1:0] SIDE_S = 2'd1;
  localparam logic [1:0] SIDE_E = 2'd2;
  localparam logic [1:0] SIDE_W = 2'd3;

  // read address select
  localparam logic [1:0] RA_CUR = 2'd0;
  localparam logic [1:0] RA_NB  = 2'd1;
  localparam logic [1:0] RA_QUE = 2'd2;

  // result select
  localparam logic [1:0] RES_MISS = 2'd0;
  localparam logic [1:0] RES_CELL = 2'd1;
  localparam logic [1:0] RES_HIT  = 2'd2;

  typedef struct packed {
    logic       load;
    logic [1:0] rsel;
    logic       wall_wr;
    logic       wall_nb;
    logic       flood_init;
    logic       pop;
    logic       cur_from_q;
    logic       latch;
    logic       side_clr;
    logic       side_inc;
    logic       flood_side;
    logic       res_ld;
    logic [1:0] res_sel;
  } mff_cmd_t;

  typedef struct packed {
    logic off;
    logic nb_ok;
    logic q_empty;
    logic d_end;
    logic hit;
    logic side_last;
  } mff_stat_t;

endpackage

@@ sv/mff_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module mff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/mff_dp.sv @@
// datapath: wall, distance and search queue stores, cell and neighbor logic
// depends on mff_pkg, mff_ram and maze_flood_fill_defines.svh
`include "maze_flood_fill_defines.svh"

module mff_dp
  import mff_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] in_cell_row,
  input  logic [2:0] in_cell_col,
  input  logic [1:0] in_wall_side,
  input  mff_cmd_t   cmd,
  output mff_stat_t  stat,
  output logic [1:0] res_dir,
  output logic [7:0] res_dist
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(GRID_SIDE);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int QW    = 2 * RW;
  localparam logic [RW-1:0] ROW_LAST = RW'(GRID_SIDE - 1);

  function automatic logic [AW-1:0] cell_idx(input logic [RW-1:0] r, input logic [RW-1:0] c);
    return AW'(int'(r) * GRID_SIDE + int'(c));
  endfunction

  logic [RW-1:0]    cur_row_r, cur_col_r;
  logic             off_r;
  logic [1:0]       side_r;
  logic [3:0]       w_r;
  logic [7:0]       d_r;
  logic [CW-1:0]    head_r, tail_r;
  logic [CELLS-1:0] dv_r, wv_r;
  logic             dvq_r, wvq_r;
  logic [1:0]       res_dir_r;
  logic [7:0]       res_dist_r;

  logic [RW-1:0] nb_row, nb_col;
  logic          nb_ok;
  logic [AW-1:0] cur_idx, nb_idx, q_idx, raddr;
  logic [QW-1:0] q_rdata, q_wdata;
  logic [AW-1:0] q_waddr;
  logic          q_we;
  logic [3:0]    walls_rdata, walls_rd_v, walls_wdata;
  logic [AW-1:0] walls_waddr;
  logic [1:0]    wall_bit;
  logic [7:0]    dist_rdata, dist_rd_v, dist_wdata;
  logic [AW-1:0] dist_waddr;
  logic          dist_we;
  logic          fs_go, init_go;

  assign cur_idx = cell_idx(cur_row_r, cur_col_r);
  assign q_idx   = cell_idx(q_rdata[QW-1:RW], q_rdata[RW-1:0]);

  always_comb begin
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    nb_ok  = 1'b0;
    unique case (side_r)
      SIDE_N: begin
        nb_ok  = cur_row_r != ROW_LAST;
        nb_row = cur_row_r + RW'(1);
      end
      SIDE_S: begin
        nb_ok  = cur_row_r != '0;
        nb_row = cur_row_r - RW'(1);
      end
      SIDE_E: begin
        nb_ok  = cur_col_r != ROW_LAST;
        nb_col = cur_col_r + RW'(1);
      end
      default: begin
        nb_ok  = cur_col_r != '0;
        nb_col = cur_col_r - RW'(1);
      end
    endcase
  end

  assign nb_idx = cell_idx(nb_row, nb_col);

  always_comb begin
    unique case (cmd.rsel)
      RA_NB:   raddr = nb_idx;
      RA_QUE:  raddr = q_idx;
      default: raddr = cur_idx;
    endcase
  end

  assign walls_rd_v = wvq_r ? walls_rdata : 4'b0000;
  assign dist_rd_v  = dvq_r ? dist_rdata : DIST_NONE;

  // wall updates
  assign wall_bit    = cmd.wall_nb ? (side_r ^ 2'b01) : side_r;
  assign walls_waddr = cmd.wall_nb ? nb_idx : cur_idx;
  assign walls_wdata = walls_rd_v | (4'b0001 << wall_bit);

  // search expansion
  assign init_go = cmd.flood_init && !off_r;
  assign fs_go   = cmd.flood_side && nb_ok && !w_r[side_r] && !dv_r[nb_idx] && (d_r < DIST_LAST);

  assign dist_we    = init_go || fs_go;
  assign dist_waddr = init_go ? cur_idx : nb_idx;
  assign dist_wdata = init_go ? 8'd0 : d_r + 8'd1;

  assign q_we    = init_go || fs_go;
  assign q_waddr = init_go ? '0 : tail_r[AW-1:0];
  assign q_wdata = init_go ? {cur_row_r, cur_col_r} : {nb_row, nb_col};

  mff_ram #(.WIDTH(4), .DEPTH(CELLS)) u_walls (
    .clk(clk), .we(cmd.wall_wr), .waddr(walls_waddr), .wdata(walls_wdata),
    .raddr(raddr), .rdata(walls_rdata)
  );

  mff_ram #(.WIDTH(8), .DEPTH(CELLS)) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(raddr), .rdata(dist_rdata)
  );

  mff_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head_r[AW-1:0]), .rdata(q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      dv_r   <= '0;
      wv_r   <= '0;
      dvq_r  <= 1'b0;
      wvq_r  <= 1'b0;
    end else begin
      dvq_r <= dv_r[raddr];
      wvq_r <= wv_r[raddr];
      if (cmd.flood_init) begin
        dv_r   <= off_r ? '0 : ({{(CELLS-1){1'b0}}, 1'b1} << cur_idx);
        head_r <= '0;
        tail_r <= off_r ? '0 : CW'(1);
      end
      if (fs_go) begin
        dv_r[nb_idx] <= 1'b1;
        tail_r       <= tail_r + CW'(1);
      end
      if (cmd.pop) begin
        head_r <= head_r + CW'(1);
      end
      if (cmd.wall_wr) begin
        wv_r[walls_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_row_r  <= RW'(in_cell_row);
      cur_col_r  <= RW'(in_cell_col);
      off_r      <= (int'(in_cell_row) >= GRID_SIDE) || (int'(in_cell_col) >= GRID_SIDE);
      side_r     <= in_wall_side;
      res_dir_r  <= SIDE_N;
      res_dist_r <= 8'd0;
    end
    if (cmd.cur_from_q) begin
      cur_row_r <= q_rdata[QW-1:RW];
      cur_col_r <= q_rdata[RW-1:0];
    end
    if (cmd.latch) begin
      w_r <= walls_rd_v;
      d_r <= dist_rd_v;
    end
    if (cmd.side_clr) begin
      side_r <= SIDE_N;
    end
    if (cmd.side_inc) begin
      side_r <= side_r + 2'd1;
    end
    if (cmd.res_ld) begin
      case (cmd.res_sel)
        RES_MISS: begin
          res_dir_r  <= SIDE_N;
          res_dist_r <= DIST_NONE;
        end
        RES_HIT: begin
          res_dir_r  <= side_r;
          res_dist_r <= d_r;
        end
        default: begin
          res_dir_r  <= SIDE_N;
          res_dist_r <= d_r;
        end
      endcase
    end
  end

  assign stat.off       = off_r;
  assign stat.nb_ok     = nb_ok;
  assign stat.q_empty   = head_r == tail_r;
  assign stat.d_end     = (d_r == 8'd0) || (d_r == DIST_NONE);
  assign stat.hit       = nb_ok && !w_r[side_r] && (dist_rd_v == d_r - 8'd1);
  assign stat.side_last = side_r == SIDE_W;

  assign res_dir  = res_dir_r;
  assign res_dist = res_dist_r;

  `MFF_ASSERT_ALWAYS(a_head_le_tail, head_r <= tail_r, "queue head passed tail")
  `MFF_ASSERT_ALWAYS(a_tail_bound, int'(tail_r) <= CELLS, "queue overflow")
  `MFF_ASSERT_IMP(a_expand_known, cmd.flood_side, d_r != DIST_NONE, "expanding unreached cell")
  `MFF_ASSERT_IMP(a_pop_nonempty, cmd.pop, head_r != tail_r, "pop from empty queue")

endmodule

@@ sv/mff_ctrl.sv @@
// controller state machine sequencing wall, flood and query requests
// depends on mff_pkg
module mff_ctrl
  import mff_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_opcode,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  mff_stat_t stat,
  output mff_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_W_A     = 4'd1;
  localparam logic [3:0] ST_W_WA    = 4'd2;
  localparam logic [3:0] ST_W_WB    = 4'd3;
  localparam logic [3:0] ST_F_INIT  = 4'd4;
  localparam logic [3:0] ST_F_POP   = 4'd5;
  localparam logic [3:0] ST_F_FETCH = 4'd6;
  localparam logic [3:0] ST_F_LATCH = 4'd7;
  localparam logic [3:0] ST_F_SIDE  = 4'd8;
  localparam logic [3:0] ST_Q_FETCH = 4'd9;
  localparam logic [3:0] ST_Q_LATCH = 4'd10;
  localparam logic [3:0] ST_Q_TEST  = 4'd11;
  localparam logic [3:0] ST_Q_RD    = 4'd12;
  localparam logic [3:0] ST_Q_CHK   = 4'd13;
  localparam logic [3:0] ST_RESP    = 4'd14;

  logic [3:0] state_r, state_nxt;

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = state_r == ST_RESP;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rsel  = RA_CUR;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_opcode)
            OP_WALL:  state_nxt = ST_W_A;
            OP_FLOOD: state_nxt = ST_F_INIT;
            OP_QUERY: state_nxt = ST_Q_FETCH;
            default:  state_nxt = ST_RESP;
          endcase
        end
      end
      ST_W_A: begin
        state_nxt = (stat.off || !stat.nb_ok) ? ST_RESP : ST_W_WA;
      end
      ST_W_WA: begin
        cmd.wall_wr = 1'b1;
        cmd.rsel    = RA_NB;
        state_nxt   = ST_W_WB;
      end
      ST_W_WB: begin
        cmd.wall_wr = 1'b1;
        cmd.wall_nb = 1'b1;
        state_nxt   = ST_RESP;
      end
      ST_F_INIT: begin
        cmd.flood_init = 1'b1;
        state_nxt      = stat.off ? ST_RESP : ST_F_POP;
      end
      ST_F_POP: begin
        if (stat.q_empty) begin
          state_nxt = ST_RESP;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = ST_F_FETCH;
        end
      end
      ST_F_FETCH: begin
        cmd.cur_from_q = 1'b1;
        cmd.rsel       = RA_QUE;
        state_nxt      = ST_F_LATCH;
      end
      ST_F_LATCH: begin
        cmd.latch    = 1'b1;
        cmd.side_clr = 1'b1;
        state_nxt    = ST_F_SIDE;
      end
      ST_F_SIDE: begin
        cmd.flood_side = 1'b1;
        cmd.side_inc   = 1'b1;
        if (stat.side_last) begin
          state_nxt = ST_F_POP;
        end
      end
      ST_Q_FETCH: begin
        if (stat.off) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_MISS;
          state_nxt   = ST_RESP;
        end else begin
          state_nxt = ST_Q_LATCH;
        end
      end
      ST_Q_LATCH: begin
        cmd.latch    = 1'b1;
        cmd.side_clr = 1'b1;
        state_nxt    = ST_Q_TEST;
      end
      ST_Q_TEST: begin
        if (stat.d_end) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_CELL;
          state_nxt   = ST_RESP;
        end else begin
          state_nxt = ST_Q_RD;
        end
      end
      ST_Q_RD: begin
        cmd.rsel  = RA_NB;
        state_nxt = ST_Q_CHK;
      end
      ST_Q_CHK: begin
        if (stat.hit) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_HIT;
          state_nxt   = ST_RESP;
        end else if (stat.side_last) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_CELL;
          state_nxt   = ST_RESP;
        end else begin
          cmd.side_inc = 1'b1;
          state_nxt    = ST_Q_RD;
        end
      end
      ST_RESP: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/maze_flood_fill.sv @@
// top level of the maze flood fill block: controller plus datapath
// depends on mff_pkg, mff_ctrl and mff_dp
//
//  channel | ports                                        | direction
//  in      | in_valid in_stall in_opcode in_cell_row      | request in
//          | in_cell_col in_wall_side                     |
//  out     | out_valid out_stall out_step_direction       | result out
//          | out_cell_distance                            |
//
// one request at a time; in_stall is high from acceptance until the result is taken
// wall, query and flood each run their own state sequence; flood work grows with the number
// of reachable cells and is bound by the single read port of the cell stores
// reset needs no clearing pass: per-cell valid bits give the reset values at once
// a stalled result holds the block until out_stall drops
module maze_flood_fill
  import mff_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [2:0] in_cell_row,
  input  logic [2:0] in_cell_col,
  input  logic [1:0] in_wall_side,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_step_direction,
  output logic [7:0] out_cell_distance
);

  mff_cmd_t  cmd;
  mff_stat_t stat;

  mff_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_opcode(in_opcode),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  mff_dp #(.GRID_SIDE(GRID_SIDE)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_cell_row(in_cell_row), .in_cell_col(in_cell_col),
    .in_wall_side(in_wall_side), .cmd(cmd), .stat(stat),
    .res_dir(out_step_direction), .res_dist(out_cell_distance)
  );

endmodule
